[rtl/circle_segment_collision_defines.svh]
// Assertion macros shared by the RTL.
`ifndef CIRCLE_SEGMENT_COLLISION_DEFINES_SVH
`define CIRCLE_SEGMENT_COLLISION_DEFINES_SVH

// Condition implies consequence in the same cycle.
`define CSC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition implies consequence in the next cycle.
`define CSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/csc_pkg.sv]
package csc_pkg;
    localparam int COORD_WIDTH_DEF = 16;
endpackage

[rtl/circle_segment_collision.sv]
// Channel   | Signals                                             | Direction
// ----------+-----------------------------------------------------+----------
// request   | i_valid, i_ready, i_circle_*, i_seg_*               | in
// result    | o_valid, o_ready, o_hit, o_closest_x, o_closest_y   | out
//
// One request enters per cycle unless a stall on the result side holds it;
// each result passes through the two one-bit-per-stage dividers on its way.
// Reset clears only the stage valid bits; no clearing pass is needed.
// A stall on the result side freezes every stage at once, so i_ready falls
// only while a finished result waits and is not taken.
`include "circle_segment_collision_defines.svh"

module circle_segment_collision #(
    parameter int COORD_WIDTH = csc_pkg::COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          i_ready,
    input  logic signed [COORD_WIDTH-1:0] i_circle_x,
    input  logic signed [COORD_WIDTH-1:0] i_circle_y,
    input  logic        [COORD_WIDTH-2:0] i_circle_radius,
    input  logic signed [COORD_WIDTH-1:0] i_seg_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_seg_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_seg_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_seg_end_y,
    output logic                          o_valid,
    input  logic                          o_ready,
    output logic                          o_hit,
    output logic signed [COORD_WIDTH-1:0] o_closest_x,
    output logic signed [COORD_WIDTH-1:0] o_closest_y
);
    localparam int W   = COORD_WIDTH;
    localparam int AW  = W + 1;        // end point differences
    localparam int P2W = 2 * W + 2;    // products and sums of second order
    localparam int NW  = 3 * W + 3;    // projection numerators
    localparam int DW  = 2 * W + 2;    // determinant
    localparam int QW  = W + 3;        // quotient magnitude
    localparam int PW  = QW + 1;       // signed projection
    localparam int SW  = 2 * W + 2;    // squared distance

    typedef struct packed {
        logic signed [W-1:0] cx;
        logic signed [W-1:0] cy;
        logic        [W-2:0] r;
        logic signed [W-1:0] x0;
        logic signed [W-1:0] y0;
        logic signed [W-1:0] x1;
        logic signed [W-1:0] y1;
        logic                pt;
        logic                vert;
    } t_geom;

    typedef struct packed {
        t_geom           g;
        logic [DW-1:0]   det;
        logic [DW-1:0]   remx;
        logic [DW-1:0]   remy;
        logic [QW-1:0]   nlx;
        logic [QW-1:0]   nly;
        logic [QW-1:0]   qx;
        logic [QW-1:0]   qy;
        logic            negx;
        logic            negy;
    } t_div;

    logic en;
    logic r_vld [0:QW+10];

    // Stage registers
    t_geom                 r_s1_g, r_s2_g, r_s3_g, r_s4_g, r_s5_g;
    logic signed [AW-1:0]  r_s1_a, r_s1_b, r_s2_a, r_s2_b, r_s3_a, r_s3_b;
    logic signed [P2W-1:0] r_s2_pa1, r_s2_pb1, r_s2_pa2, r_s2_pb2, r_s2_aa, r_s2_bb;
    logic signed [P2W-1:0] r_s3_c1, r_s3_c2;
    logic        [DW-1:0]  r_s3_det, r_s4_det, r_s5_det;
    logic signed [NW-1:0]  r_s4_m1, r_s4_m2, r_s4_m3, r_s4_m4, r_s5_nx, r_s5_ny;
    t_div                  r_dv [0:QW];
    t_geom                 r_s7_g, r_s8_g;
    logic signed [PW-1:0]  r_s7_px, r_s7_py;
    logic signed [W-1:0]   r_s8_px, r_s8_py, r_s9_px, r_s9_py, r_s10_px, r_s10_py;
    logic signed [AW-1:0]  r_s9_dx, r_s9_dy;
    logic        [W-2:0]   r_s9_r;
    logic        [SW-1:0]  r_s10_d2, r_s10_r2;
    t_geom                 r_s9_g, r_s10_g, r_out_g;
    logic                  r_out_hit;
    logic signed [W-1:0]   r_out_px, r_out_py;

    logic [NW-1:0]         n_magx, n_magy;
    t_div                  n_dv0;
    logic signed [PW-1:0]  n_px_raw, n_py_raw;
    logic signed [W-1:0]   n_clx, n_cly;

    assign en      = !r_vld[QW+10] || o_ready;
    assign i_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QW + 10; k++) r_vld[k] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k <= QW + 10; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // Stage 1: capture and form the line coefficients.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_g.cx   <= i_circle_x;
            r_s1_g.cy   <= i_circle_y;
            r_s1_g.r    <= i_circle_radius;
            r_s1_g.x0   <= i_seg_start_x;
            r_s1_g.y0   <= i_seg_start_y;
            r_s1_g.x1   <= i_seg_end_x;
            r_s1_g.y1   <= i_seg_end_y;
            r_s1_g.vert <= (i_seg_start_x == i_seg_end_x);
            r_s1_g.pt   <= (i_seg_start_x == i_seg_end_x) && (i_seg_start_y == i_seg_end_y);
            r_s1_a      <= AW'(i_seg_start_y) - AW'(i_seg_end_y);
            r_s1_b      <= AW'(i_seg_end_x) - AW'(i_seg_start_x);
        end
    end

    // Stages 2 to 5: products, sums, numerator products, numerator sums.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_g   <= r_s1_g;
            r_s2_a   <= r_s1_a;
            r_s2_b   <= r_s1_b;
            r_s2_pa1 <= P2W'(r_s1_a) * P2W'($signed(r_s1_g.x1));
            r_s2_pb1 <= P2W'(r_s1_b) * P2W'($signed(r_s1_g.y1));
            r_s2_pa2 <= P2W'(r_s1_a) * P2W'($signed(r_s1_g.cy));
            r_s2_pb2 <= P2W'(r_s1_b) * P2W'($signed(r_s1_g.cx));
            r_s2_aa  <= P2W'(r_s1_a) * P2W'(r_s1_a);
            r_s2_bb  <= P2W'(r_s1_b) * P2W'(r_s1_b);

            r_s3_g   <= r_s2_g;
            r_s3_a   <= r_s2_a;
            r_s3_b   <= r_s2_b;
            r_s3_c1  <= r_s2_pa1 + r_s2_pb1;
            r_s3_c2  <= r_s2_pa2 - r_s2_pb2;
            r_s3_det <= DW'(r_s2_aa + r_s2_bb);

            r_s4_g   <= r_s3_g;
            r_s4_det <= r_s3_det;
            r_s4_m1  <= NW'(r_s3_a) * NW'(r_s3_c1);
            r_s4_m2  <= NW'(r_s3_b) * NW'(r_s3_c2);
            r_s4_m3  <= NW'(r_s3_a) * NW'(r_s3_c2);
            r_s4_m4  <= NW'(r_s3_b) * NW'(r_s3_c1);

            r_s5_g   <= r_s4_g;
            r_s5_det <= r_s4_det;
            r_s5_nx  <= r_s4_m1 - r_s4_m2;
            r_s5_ny  <= r_s4_m3 + r_s4_m4;
        end
    end

    // Divider entry: split sign and magnitude, preload the high remainder.
    always_comb begin
        n_magx        = r_s5_nx[NW-1] ? NW'(-r_s5_nx) : NW'(r_s5_nx);
        n_magy        = r_s5_ny[NW-1] ? NW'(-r_s5_ny) : NW'(r_s5_ny);
        n_dv0.g       = r_s5_g;
        n_dv0.det     = r_s5_det;
        n_dv0.remx    = DW'(n_magx >> QW);
        n_dv0.remy    = DW'(n_magy >> QW);
        n_dv0.nlx     = n_magx[QW-1:0];
        n_dv0.nly     = n_magy[QW-1:0];
        n_dv0.qx      = '0;
        n_dv0.qy      = '0;
        n_dv0.negx    = r_s5_nx[NW-1];
        n_dv0.negy    = r_s5_ny[NW-1];
    end

    always_ff @(posedge i_clk) begin
        if (en) r_dv[0] <= n_dv0;
    end

    // One restoring step per stage, both quotients side by side.
    for (genvar k = 1; k <= QW; k++) begin : g_div
        logic [DW:0] n_trx, n_try;
        logic        n_gex, n_gey;
        t_div        n_dv;

        always_comb begin
            n_trx     = {r_dv[k-1].remx, r_dv[k-1].nlx[QW-1]};
            n_try     = {r_dv[k-1].remy, r_dv[k-1].nly[QW-1]};
            n_gex     = n_trx >= {1'b0, r_dv[k-1].det};
            n_gey     = n_try >= {1'b0, r_dv[k-1].det};
            n_dv      = r_dv[k-1];
            n_dv.remx = n_gex ? DW'(n_trx - {1'b0, r_dv[k-1].det}) : DW'(n_trx);
            n_dv.remy = n_gey ? DW'(n_try - {1'b0, r_dv[k-1].det}) : DW'(n_try);
            n_dv.nlx  = r_dv[k-1].nlx << 1;
            n_dv.nly  = r_dv[k-1].nly << 1;
            n_dv.qx   = {r_dv[k-1].qx[QW-2:0], n_gex};
            n_dv.qy   = {r_dv[k-1].qy[QW-2:0], n_gey};
        end

        always_ff @(posedge i_clk) begin
            if (en) r_dv[k] <= n_dv;
        end
    end

    // Signed projection; a zero determinant falls back to the center.
    always_comb begin
        if (r_dv[QW].det == '0) begin
            n_px_raw = PW'($signed(r_dv[QW].g.cx));
            n_py_raw = PW'($signed(r_dv[QW].g.cy));
        end else begin
            n_px_raw = r_dv[QW].negx ? -$signed({1'b0, r_dv[QW].qx})
                                     : $signed({1'b0, r_dv[QW].qx});
            n_py_raw = r_dv[QW].negy ? -$signed({1'b0, r_dv[QW].qy})
                                     : $signed({1'b0, r_dv[QW].qy});
        end
    end

    // Clamp to the end points, along y for a vertical segment; a point segment gives its start.
    always_comb begin
        logic                fl;
        logic signed [W-1:0] lx, ly, hx, hy;
        logic                below, above;
        fl    = r_s7_g.vert ? ($signed(r_s7_g.y0) < $signed(r_s7_g.y1))
                            : ($signed(r_s7_g.x0) < $signed(r_s7_g.x1));
        lx    = fl ? r_s7_g.x0 : r_s7_g.x1;
        ly    = fl ? r_s7_g.y0 : r_s7_g.y1;
        hx    = fl ? r_s7_g.x1 : r_s7_g.x0;
        hy    = fl ? r_s7_g.y1 : r_s7_g.y0;
        below = r_s7_g.vert ? (PW'(ly) > r_s7_py) : (PW'(lx) > r_s7_px);
        above = r_s7_g.vert ? (PW'(hy) < r_s7_py) : (PW'(hx) < r_s7_px);
        if (r_s7_g.pt) begin
            n_clx = r_s7_g.x0;
            n_cly = r_s7_g.y0;
        end else if (below) begin
            n_clx = lx;
            n_cly = ly;
        end else if (above) begin
            n_clx = hx;
            n_cly = hy;
        end else begin
            n_clx = W'(r_s7_px);
            n_cly = W'(r_s7_py);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s7_g    <= r_dv[QW].g;
            r_s7_px   <= n_px_raw;
            r_s7_py   <= n_py_raw;

            r_s8_g    <= r_s7_g;
            r_s8_px   <= n_clx;
            r_s8_py   <= n_cly;

            r_s9_g    <= r_s8_g;
            r_s9_px   <= r_s8_px;
            r_s9_py   <= r_s8_py;
            r_s9_r    <= r_s8_g.r;
            r_s9_dx   <= AW'(r_s8_px) - AW'($signed(r_s8_g.cx));
            r_s9_dy   <= AW'(r_s8_py) - AW'($signed(r_s8_g.cy));

            r_s10_g   <= r_s9_g;
            r_s10_px  <= r_s9_px;
            r_s10_py  <= r_s9_py;
            r_s10_d2  <= SW'(SW'(r_s9_dx) * SW'(r_s9_dx)) + SW'(SW'(r_s9_dy) * SW'(r_s9_dy));
            r_s10_r2  <= SW'(r_s9_r) * SW'(r_s9_r);

            r_out_g   <= r_s10_g;
            r_out_px  <= r_s10_px;
            r_out_py  <= r_s10_py;
            r_out_hit <= (r_s10_d2 <= r_s10_r2);
        end
    end

    assign o_valid     = r_vld[QW+10];
    assign o_hit       = r_out_hit;
    assign o_closest_x = r_out_px;
    assign o_closest_y = r_out_py;

    `CSC_ASSERT_SAME(a_stall_blocks_input, i_clk, i_rst_n,
        o_valid && !o_ready, !i_ready, "input taken while result is stalled")
    `CSC_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n,
        i_valid && i_ready, r_vld[0], "accepted request did not enter the pipeline")
    `CSC_ASSERT_SAME(a_x_in_box, i_clk, i_rst_n, o_valid,
        ((o_closest_x >= $signed(r_out_g.x0)) || (o_closest_x >= $signed(r_out_g.x1)))
        && ((o_closest_x <= $signed(r_out_g.x0)) || (o_closest_x <= $signed(r_out_g.x1))),
        "closest x outside the segment")
    `CSC_ASSERT_SAME(a_point_segment, i_clk, i_rst_n, o_valid && r_out_g.pt,
        (o_closest_x == r_out_g.x0) && (o_closest_y == r_out_g.y0),
        "point segment gave another point")

endmodule

[dv/csc_checker.sv]
`timescale 1ns / 1ps

module csc_checker #(
    parameter int COORD_WIDTH = csc_pkg::COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          i_ready,
    input  logic signed [COORD_WIDTH-1:0] i_circle_x,
    input  logic signed [COORD_WIDTH-1:0] i_circle_y,
    input  logic        [COORD_WIDTH-2:0] i_circle_radius,
    input  logic signed [COORD_WIDTH-1:0] i_seg_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_seg_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_seg_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_seg_end_y,
    input  logic                          o_valid,
    input  logic                          o_ready,
    input  logic                          o_hit,
    input  logic signed [COORD_WIDTH-1:0] o_closest_x,
    input  logic signed [COORD_WIDTH-1:0] o_closest_y,
    output int                            o_errors,
    output int                            o_pending
);

    typedef struct packed {
        logic                          hit;
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
    } t_nearest;

    t_nearest nearest_q[$];

    // Truncating division toward zero.
    function automatic longint div_trunc(longint n, longint d);
        longint q;
        q = (n < 0 ? -n : n) / (d < 0 ? -d : d);
        return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    function automatic t_nearest find_nearest(
        longint cx, longint cy, longint r,
        longint x0, longint y0, longint x1, longint y1);
        longint a, b, c1, c2, det, px, py, lx, ly, hx, hy, dx, dy;
        t_nearest res;
        if (x0 == x1 && y0 == y1) begin
            px = x0;
            py = y0;
        end else begin
            a = y0 - y1;
            b = x1 - x0;
            c1 = a * x1 + b * y1;
            c2 = a * cy - b * cx;
            det = a * a + b * b;
            if (det != 0) begin
                px = div_trunc(a * c1 - b * c2, det);
                py = div_trunc(a * c2 + b * c1, det);
            end else begin
                px = cx;
                py = cy;
            end
            // Clamp along x, or along y for a vertical segment.
            if (x0 != x1) begin
                if (x0 < x1) begin lx = x0; ly = y0; hx = x1; hy = y1; end
                else begin lx = x1; ly = y1; hx = x0; hy = y0; end
                if (lx > px) begin px = lx; py = ly; end
                else if (hx < px) begin px = hx; py = hy; end
            end else begin
                if (y0 < y1) begin lx = x0; ly = y0; hx = x1; hy = y1; end
                else begin lx = x1; ly = y1; hx = x0; hy = y0; end
                if (ly > py) begin px = lx; py = ly; end
                else if (hy < py) begin px = hx; py = hy; end
            end
        end
        dx = px - cx;
        dy = py - cy;
        res.hit = (dx * dx + dy * dy) <= r * r;
        res.x = px[COORD_WIDTH-1:0];
        res.y = py[COORD_WIDTH-1:0];
        return res;
    endfunction

    assign o_pending = nearest_q.size();

    always @(posedge i_clk) begin
        t_nearest want;
        if (!i_rst_n) begin
            o_errors <= 0;
        end else begin
            if (i_valid && i_ready) begin
                nearest_q.push_back(find_nearest(i_circle_x, i_circle_y, i_circle_radius,
                    i_seg_start_x, i_seg_start_y, i_seg_end_x, i_seg_end_y));
            end
            if (o_valid && o_ready) begin
                if (nearest_q.size() == 0) begin
                    $display("%0t: result with no request waiting: hit %0d x %0d y %0d",
                        $time, o_hit, o_closest_x, o_closest_y);
                    o_errors <= o_errors + 1;
                end else begin
                    want = nearest_q.pop_front();
                    if (want.hit !== o_hit || want.x !== o_closest_x
                            || want.y !== o_closest_y) begin
                        $display("%0t: expected hit %0d x %0d y %0d, got hit %0d x %0d y %0d",
                            $time, want.hit, want.x, want.y,
                            o_hit, o_closest_x, o_closest_y);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    localparam int CW = csc_pkg::COORD_WIDTH_DEF;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 i_ready;
    logic signed [CW-1:0] i_circle_x = '0;
    logic signed [CW-1:0] i_circle_y = '0;
    logic        [CW-2:0] i_circle_radius = '0;
    logic signed [CW-1:0] i_seg_start_x = '0;
    logic signed [CW-1:0] i_seg_start_y = '0;
    logic signed [CW-1:0] i_seg_end_x = '0;
    logic signed [CW-1:0] i_seg_end_y = '0;
    logic                 o_valid;
    logic                 o_ready = 1'b0;
    logic                 o_hit;
    logic signed [CW-1:0] o_closest_x;
    logic signed [CW-1:0] o_closest_y;
    int                   errors;
    int                   pending;
    int                   send_idle_pct = 21;
    int                   recv_idle_pct = 47;
    logic                 hold_off = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    circle_segment_collision i_dut (.*);

    csc_checker i_checker (
        .i_clk, .i_rst_n, .i_valid, .i_ready, .i_circle_x, .i_circle_y,
        .i_circle_radius, .i_seg_start_x, .i_seg_start_y, .i_seg_end_x,
        .i_seg_end_y, .o_valid, .o_ready, .o_hit, .o_closest_x, .o_closest_y,
        .o_errors(errors), .o_pending(pending)
    );

    // Result side: random stalls, plus a long hold-off when asked.
    always @(negedge i_clk) begin
        o_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic [CW-1:0] pick_coord();
        case ($urandom_range(5))
            0: return {1'b0, {(CW-1){1'b1}}};
            1: return {1'b1, {(CW-1){1'b0}}};
            2: return CW'($signed($urandom_range(200)) - 100);
            default: return CW'($urandom);
        endcase
    endfunction

    // Valid drops only while the sender idles, so it is written once per step.
    task automatic send_request(logic [CW-1:0] cx, logic [CW-1:0] cy, logic [CW-2:0] r,
        logic [CW-1:0] x0, logic [CW-1:0] y0, logic [CW-1:0] x1, logic [CW-1:0] y1);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_circle_x <= cx;
        i_circle_y <= cy;
        i_circle_radius <= r;
        i_seg_start_x <= x0;
        i_seg_start_y <= y0;
        i_seg_end_x <= x1;
        i_seg_end_y <= y1;
        do @(posedge i_clk); while (!(i_valid && i_ready));
        @(negedge i_clk);
    endtask

    task automatic send_random();
        logic [CW-1:0] x0, y0, x1, y1;
        x0 = pick_coord();
        y0 = pick_coord();
        x1 = pick_coord();
        y1 = pick_coord();
        // Occasionally make the segment vertical, horizontal or a point.
        case ($urandom_range(9))
            0: x1 = x0;
            1: y1 = y0;
            2: begin x1 = x0; y1 = y0; end
            default: ;
        endcase
        send_request(pick_coord(), pick_coord(),
            $urandom_range(3) == 0 ? (CW-1)'($urandom) : (CW-1)'($urandom_range(2000)),
            x0, y0, x1, y1);
    endtask

    localparam logic [CW-1:0] MAXC = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] MINC = {1'b1, {(CW-1){1'b0}}};

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        // Directed: extremes, point-like, vertical, horizontal, clamp at each end.
        send_request(0, 0, 0, 0, 0, 0, 0);
        send_request(MAXC, MAXC, '1, MINC, MINC, MINC, MINC);
        send_request(MINC, MINC, '1, MAXC, MAXC, MAXC, MAXC);
        send_request(16, 16, 16, 16, 16, 16, 16);
        send_request(0, 0, 10, 5, -100, 5, 100);
        send_request(0, 500, 10, 5, -100, 5, 100);
        send_request(0, -500, 10, 5, 100, 5, -100);
        send_request(50, 3, 5, -100, 0, 100, 0);
        send_request(500, 3, 5, 100, 0, -100, 0);
        send_request(-500, 3, 600, -100, 0, 100, 0);
        send_request(MINC, MAXC, '1, MINC, MINC, MAXC, MAXC);
        send_request(MAXC, MINC, '1, MAXC, MINC, MINC, MAXC);
        send_request(MINC, MINC, 0, MAXC, MINC, MINC, MAXC);
        send_request(3, 7, 2, 0, 0, 9, 13);
        send_request(-33, 41, 100, -20, -20, 30, 70);
        send_request('1, '1, '1, '1, '1, '1, '1);
        send_request(1, 1, 1, MINC, MAXC, MAXC, MINC);
        repeat (330) send_random();
        send_idle_pct = 47;
        recv_idle_pct = 21;
        // Long receiver hold-off so the pipeline fills and stalls requests.
        fork
            begin
                hold_off = 1'b1;
                repeat (200) @(negedge i_clk);
                hold_off = 1'b0;
            end
            repeat (60) send_random();
        join
        repeat (270) send_random();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (330) send_random();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule
